[rtl/lcdg_pkg.sv]
// ----------------------------------------------------------------------------
// lcdg_pkg
// Shared types, codes and saturating helpers for the lasso coordinate
// descent block.
// ----------------------------------------------------------------------------
package lcdg_pkg;

  localparam int VALUE_W  = 32;
  localparam int IDX_FW   = 4;
  localparam int SWEEP_W  = 16;
  localparam int LAMBDA_W = 31;
  localparam int TOL_W    = 32;
  localparam int SIZE_W   = 5;
  localparam int CFG_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_GRAM   = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_COEF   = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LAMBDA   = 2'd0,
    REG_MAX_ITER = 2'd1,
    REG_TOL      = 2'd2,
    REG_SIZE     = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_INIT_RD, OP_INIT_WR,
    OP_DOT_RD, OP_DOT_MUL, OP_DOT_ACC,
    OP_UPD_T, OP_UPD_A, OP_UPD_S, OP_DIV_GO, OP_UPD_WR,
    OP_ST_RD, OP_ST_MUL, OP_ST_ACC,
    OP_CV_A, OP_CV_B,
    OP_CP_RD, OP_CP_WR,
    OP_OUT_RD, OP_OUT_LD
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic               first_i;
    logic               diag;
    logic               first_j;
    logic               last;
    logic               conv;
    logic [SWEEP_W-1:0] sweeps;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic conv_hit;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? INT64_MIN : INT64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? INT64_MIN : INT64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] usat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

[rtl/lcdg_if.sv]
// ----------------------------------------------------------------------------
// lcdg_if
// Valid/ready channels for input items and fitted coefficients.
// ----------------------------------------------------------------------------
interface lcdg_in_if;
  import lcdg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [IDX_FW-1:0]         row_index;
  logic [IDX_FW-1:0]         col_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, row_index, col_index, value, input ready);
  modport sink   (input valid, command, row_index, col_index, value, output ready);
endinterface

interface lcdg_out_if;
  import lcdg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [IDX_FW-1:0]         coef_index;
  logic signed [VALUE_W-1:0] coef_value;
  logic [SWEEP_W-1:0]        sweeps_done;
  logic                      converged;
  logic                      bad_diagonal;
  logic                      last;

  modport source (output valid, coef_index, coef_value, sweeps_done, converged,
                  bad_diagonal, last, input ready);
  modport sink   (input valid, coef_index, coef_value, sweeps_done, converged,
                  bad_diagonal, last, output ready);
endinterface

[rtl/lcdg_ram.sv]
// ----------------------------------------------------------------------------
// lcdg_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module lcdg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lcdg_div.sv]
// ----------------------------------------------------------------------------
// lcdg_div
// Restoring divider, one quotient bit per cycle: 64-bit signed dividend by a
// positive 32-bit divisor, truncated toward zero, as magnitude and sign.
// ----------------------------------------------------------------------------
module lcdg_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [31:0]        divisor,
  output logic               busy,
  output logic [63:0]        quot_mag,
  output logic               quot_neg
);

  logic [63:0] num;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] shifted;
  logic        fits;

  assign shifted  = {rem[31:0], num[63]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quot_mag = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem      <= '0;
      dvs      <= divisor;
      quot_neg <= dividend[63];
      cnt      <= '0;
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, dvs} : shifted;
      num <= {num[62:0], fits};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

[rtl/lcdg_datapath.sv]
// ----------------------------------------------------------------------------
// lcdg_datapath
// Stores, multiply-accumulate, soft threshold, divider, convergence test and
// the output register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module lcdg_datapath
  import lcdg_pkg::*;
#(
  parameter int MAX_COEFS = 16,
  parameter int FRAC_BITS = 16,
  parameter int IDX_W     = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lcdg_pkg::ctl_cmd_t           cmd,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [IDX_W-1:0]             idx_j,
  input  logic [1:0]                   ld_command,
  input  logic [lcdg_pkg::IDX_FW-1:0]  ld_row,
  input  logic [lcdg_pkg::IDX_FW-1:0]  ld_col,
  input  logic [lcdg_pkg::VALUE_W-1:0] ld_value,
  input  logic [lcdg_pkg::LAMBDA_W-1:0] lambda,
  input  logic [lcdg_pkg::TOL_W-1:0]   tol,
  output lcdg_pkg::dp_sts_t            sts,
  lcdg_out_if.source                   coefs
);

  localparam int GDEPTH = MAX_COEFS * MAX_COEFS;
  localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;

  logic              row_ok, col_ok;
  logic              gram_we, gram_re, targ_we, targ_re;
  logic              coef_we, coef_re, prev_we, prev_re;
  logic [GA_W-1:0]   gram_waddr, gram_raddr;
  logic [IDX_W-1:0]  row_idx, coef_waddr, coef_raddr;
  logic [VALUE_W-1:0] gram_q, targ_q, coef_q, prev_q, coef_wdata, upd_val;

  logic signed [63:0] prod, dot, pjj, t, s;
  logic signed [31:0] d;
  logic               bad;
  logic [63:0]        sq_d, sq_p, chg, psum, pa, pb;

  logic signed [63:0] y64, lam;
  logic signed [32:0] df;
  logic [31:0]        ad;
  logic [64:0]        qf;
  logic [63:0]        q;
  logic               div_busy, quot_neg;
  logic [63:0]        quot_mag;

  assign row_ok  = 32'(ld_row) < MAX_COEFS;
  assign col_ok  = 32'(ld_col) < MAX_COEFS;
  assign row_idx = IDX_W'(ld_row);

  assign gram_we    = cmd.op == OP_LOAD && ld_command == CMD_GRAM && row_ok && col_ok;
  assign gram_waddr = GA_W'(32'(ld_row) * MAX_COEFS + 32'(ld_col));
  assign gram_re    = cmd.op == OP_INIT_RD || cmd.op == OP_DOT_RD;
  assign gram_raddr = (cmd.op == OP_INIT_RD) ? GA_W'(32'(idx_j) * MAX_COEFS + 32'(idx_j))
                                             : GA_W'(32'(idx_i) * MAX_COEFS + 32'(idx_j));

  assign targ_we = cmd.op == OP_LOAD && ld_command == CMD_TARGET && row_ok;
  assign targ_re = cmd.op == OP_DOT_RD;

  assign coef_we    = (cmd.op == OP_LOAD && ld_command == CMD_COEF && row_ok) ||
                      cmd.op == OP_UPD_WR;
  assign coef_waddr = (cmd.op == OP_LOAD) ? row_idx : idx_j;
  assign coef_wdata = (cmd.op == OP_LOAD) ? ld_value : upd_val;
  assign coef_re    = cmd.op == OP_INIT_RD || cmd.op == OP_DOT_RD || cmd.op == OP_ST_RD ||
                      cmd.op == OP_CP_RD || cmd.op == OP_OUT_RD;
  assign coef_raddr = (cmd.op == OP_DOT_RD) ? idx_i : idx_j;

  assign prev_we = cmd.op == OP_INIT_WR || cmd.op == OP_CP_WR;
  assign prev_re = cmd.op == OP_ST_RD;

  lcdg_ram #(.WIDTH(VALUE_W), .DEPTH(GDEPTH)) u_gram (
    .clk, .we(gram_we), .waddr(gram_waddr), .wdata(ld_value),
    .re(gram_re), .raddr(gram_raddr), .rdata(gram_q)
  );

  lcdg_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COEFS)) u_target (
    .clk, .we(targ_we), .waddr(row_idx), .wdata(ld_value),
    .re(targ_re), .raddr(idx_j), .rdata(targ_q)
  );

  lcdg_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COEFS)) u_coef (
    .clk, .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .re(coef_re), .raddr(coef_raddr), .rdata(coef_q)
  );

  lcdg_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COEFS)) u_prev (
    .clk, .we(prev_we), .waddr(idx_j), .wdata(coef_q),
    .re(prev_re), .raddr(idx_j), .rdata(prev_q)
  );

  lcdg_div u_div (
    .clk, .rst, .start(cmd.op == OP_DIV_GO), .dividend(s), .divisor(d),
    .busy(div_busy), .quot_mag, .quot_neg
  );

  // Quotient saturated to 32 bits; a non-positive diagonal forces zero.
  always_comb begin
    if (d <= 0) begin
      upd_val = '0;
    end else if (quot_neg) begin
      upd_val = (quot_mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quot_mag);
    end else begin
      upd_val = (quot_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot_mag[31:0];
    end
  end

  assign y64 = 64'(signed'(targ_q)) <<< FRAC_BITS;
  assign lam = 64'(lambda) << FRAC_BITS;
  assign df  = 33'(signed'(coef_q)) - 33'(signed'(prev_q));
  assign ad  = df[32] ? 32'(-df) : df[31:0];

  // change < eps * prev / 2^32, with the quotient saturated at 2^64-1
  assign qf = {1'b0, pb} + {33'd0, pa[63:32]};
  assign q  = qf[64] ? '1 : qf[63:0];

  assign sts.div_busy = div_busy;
  assign sts.conv_hit = chg < q || (chg == q && pa[31:0] != '0);
  assign sts.out_free = !coefs.valid || coefs.ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT_WR: bad <= (cmd.first_j ? 1'b0 : bad) | (signed'(gram_q) <= 0);
      OP_DOT_MUL: begin
        prod <= signed'(gram_q) * signed'(coef_q);
        if (cmd.diag) begin
          d <= signed'(gram_q);
        end
      end
      OP_DOT_ACC: begin
        dot <= sat_add64(cmd.first_i ? 64'sd0 : dot, prod);
        if (cmd.diag) begin
          pjj <= prod;
        end
      end
      OP_UPD_T: t <= sat_sub64(y64, dot);
      OP_UPD_A: t <= sat_add64(t, pjj);
      OP_UPD_S: begin
        if (t > lam) begin
          s <= t - lam;
        end else if (t < -lam) begin
          s <= t + lam;
        end else begin
          s <= '0;
        end
      end
      OP_ST_MUL: begin
        sq_d <= ad * ad;
        sq_p <= signed'(prev_q) * signed'(prev_q);
      end
      OP_ST_ACC: begin
        chg  <= usat_add64(cmd.first_j ? 64'd0 : chg, sq_d);
        psum <= usat_add64(cmd.first_j ? 64'd0 : psum, sq_p);
      end
      OP_CV_A: pa <= tol * psum[31:0];
      OP_CV_B: pb <= tol * psum[63:32];
      default: ;
    endcase
  end

  // Output register: load a coefficient when the slot is free, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.valid <= 1'b0;
    end else if (cmd.op == OP_OUT_LD && sts.out_free) begin
      coefs.valid <= 1'b1;
    end else if (coefs.ready) begin
      coefs.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_LD && sts.out_free) begin
      coefs.coef_index   <= IDX_FW'(idx_j);
      coefs.coef_value   <= coef_q;
      coefs.sweeps_done  <= cmd.sweeps;
      coefs.converged    <= cmd.conv;
      coefs.bad_diagonal <= bad;
      coefs.last         <= cmd.last;
    end
  end

endmodule

[rtl/lcdg_ctrl.sv]
// ----------------------------------------------------------------------------
// lcdg_ctrl
// Run sequencer: initial copy, sweeps of coordinate updates, convergence test,
// previous-coefficient copy and the output pass.
// ----------------------------------------------------------------------------
module lcdg_ctrl
  import lcdg_pkg::*;
#(
  parameter int MAX_COEFS = 16,
  parameter int IDX_W     = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [1:0]                   in_command,
  output logic                         in_ready,
  input  logic [lcdg_pkg::SWEEP_W-1:0] max_iter,
  input  logic [lcdg_pkg::SIZE_W-1:0]  size_in_use,
  input  lcdg_pkg::dp_sts_t            sts,
  output lcdg_pkg::ctl_cmd_t           cmd,
  output logic [IDX_W-1:0]             idx_i,
  output logic [IDX_W-1:0]             idx_j
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT_RD, ST_INIT_WR,
    ST_DOT_RD, ST_DOT_MUL, ST_DOT_ACC,
    ST_UPD_T, ST_UPD_A, ST_UPD_S, ST_DIV_GO, ST_DIV_WAIT, ST_UPD_WR,
    ST_ST_RD, ST_ST_MUL, ST_ST_ACC,
    ST_CV_A, ST_CV_B, ST_CV_C,
    ST_CP_RD, ST_CP_WR,
    ST_OUT_RD, ST_OUT_LD
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   nm1;
  logic [SWEEP_W-1:0] sweeps;
  logic               conv;
  logic [IDX_W-1:0]   nm1_next;
  logic               j_last;

  assign in_ready = state == ST_IDLE;
  assign j_last   = idx_j == nm1;

  always_comb begin
    if (size_in_use == '0) begin
      nm1_next = '0;
    end else if (32'(size_in_use) > MAX_COEFS) begin
      nm1_next = IDX_W'(MAX_COEFS - 1);
    end else begin
      nm1_next = IDX_W'(32'(size_in_use) - 1);
    end
  end

  always_comb begin
    cmd.first_i = idx_i == '0;
    cmd.diag    = idx_i == idx_j;
    cmd.first_j = idx_j == '0;
    cmd.last    = j_last;
    cmd.conv    = conv;
    cmd.sweeps  = sweeps;
    case (state)
      ST_IDLE:    cmd.op = (in_valid && in_command != CMD_RUN) ? OP_LOAD : OP_NONE;
      ST_INIT_RD: cmd.op = OP_INIT_RD;
      ST_INIT_WR: cmd.op = OP_INIT_WR;
      ST_DOT_RD:  cmd.op = OP_DOT_RD;
      ST_DOT_MUL: cmd.op = OP_DOT_MUL;
      ST_DOT_ACC: cmd.op = OP_DOT_ACC;
      ST_UPD_T:   cmd.op = OP_UPD_T;
      ST_UPD_A:   cmd.op = OP_UPD_A;
      ST_UPD_S:   cmd.op = OP_UPD_S;
      ST_DIV_GO:  cmd.op = OP_DIV_GO;
      ST_UPD_WR:  cmd.op = OP_UPD_WR;
      ST_ST_RD:   cmd.op = OP_ST_RD;
      ST_ST_MUL:  cmd.op = OP_ST_MUL;
      ST_ST_ACC:  cmd.op = OP_ST_ACC;
      ST_CV_A:    cmd.op = OP_CV_A;
      ST_CV_B:    cmd.op = OP_CV_B;
      ST_CP_RD:   cmd.op = OP_CP_RD;
      ST_CP_WR:   cmd.op = OP_CP_WR;
      ST_OUT_RD:  cmd.op = OP_OUT_RD;
      ST_OUT_LD:  cmd.op = OP_OUT_LD;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx_i  <= '0;
      idx_j  <= '0;
      nm1    <= '0;
      sweeps <= '0;
      conv   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_command == CMD_RUN) begin
            nm1    <= nm1_next;
            idx_i  <= '0;
            idx_j  <= '0;
            sweeps <= '0;
            conv   <= 1'b0;
            state  <= ST_INIT_RD;
          end
        end
        ST_INIT_RD: state <= ST_INIT_WR;
        ST_INIT_WR: begin
          if (j_last) begin
            idx_j <= '0;
            idx_i <= '0;
            state <= (max_iter == '0) ? ST_OUT_RD : ST_DOT_RD;
          end else begin
            idx_j <= idx_j + 1'b1;
            state <= ST_INIT_RD;
          end
        end
        ST_DOT_RD:  state <= ST_DOT_MUL;
        ST_DOT_MUL: state <= ST_DOT_ACC;
        ST_DOT_ACC: begin
          if (idx_i == nm1) begin
            state <= ST_UPD_T;
          end else begin
            idx_i <= idx_i + 1'b1;
            state <= ST_DOT_RD;
          end
        end
        ST_UPD_T:  state <= ST_UPD_A;
        ST_UPD_A:  state <= ST_UPD_S;
        ST_UPD_S:  state <= ST_DIV_GO;
        ST_DIV_GO: state <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!sts.div_busy) begin
            state <= ST_UPD_WR;
          end
        end
        ST_UPD_WR: begin
          idx_i <= '0;
          if (j_last) begin
            idx_j  <= '0;
            sweeps <= sweeps + 1'b1;
            state  <= ST_ST_RD;
          end else begin
            idx_j <= idx_j + 1'b1;
            state <= ST_DOT_RD;
          end
        end
        ST_ST_RD:  state <= ST_ST_MUL;
        ST_ST_MUL: state <= ST_ST_ACC;
        ST_ST_ACC: begin
          if (j_last) begin
            idx_j <= '0;
            state <= ST_CV_A;
          end else begin
            idx_j <= idx_j + 1'b1;
            state <= ST_ST_RD;
          end
        end
        ST_CV_A: state <= ST_CV_B;
        ST_CV_B: state <= ST_CV_C;
        ST_CV_C: begin
          if (sts.conv_hit) begin
            conv  <= 1'b1;
            state <= ST_OUT_RD;
          end else if (sweeps == max_iter) begin
            state <= ST_OUT_RD;
          end else begin
            state <= ST_CP_RD;
          end
        end
        ST_CP_RD: state <= ST_CP_WR;
        ST_CP_WR: begin
          if (j_last) begin
            idx_j <= '0;
            idx_i <= '0;
            state <= ST_DOT_RD;
          end else begin
            idx_j <= idx_j + 1'b1;
            state <= ST_CP_RD;
          end
        end
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          if (sts.out_free) begin
            if (j_last) begin
              state <= ST_IDLE;
            end else begin
              idx_j <= idx_j + 1'b1;
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_GO |=> sts.div_busy)
    else $error("divider not busy after start");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> (idx_j <= nm1 && idx_i <= nm1))
    else $error("coefficient index beyond size in use");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_LD && sts.out_free && j_last) |=> state == ST_IDLE)
    else $error("run did not end after final coefficient");
`endif

endmodule

[rtl/lasso_coordinate_descent_gram.sv]
// ----------------------------------------------------------------------------
// lasso_coordinate_descent_gram
// Lasso fit by Gauss-Seidel coordinate descent on a stored Gram matrix.
// ----------------------------------------------------------------------------
// Loads: one per cycle, back to back, while idle. A run holds input off for
// its initial copy, its sweeps (the last sweep skips its copy) and the output
// pass plus output stalls; the divider wait and the multiply-accumulate per
// term set the sweep. Reset (rst, synchronous) returns to idle and restores
// register defaults; the stores keep their contents and are undefined until
// written.
module lasso_coordinate_descent_gram
  import lcdg_pkg::*;
#(
  parameter int MAX_COEFS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [lcdg_pkg::REG_IDX_W-1:0] register_index,
  input  logic [lcdg_pkg::CFG_W-1:0]     write_data,
  lcdg_in_if.sink                        items,
  lcdg_out_if.source                     coefs
);

  localparam int IDX_W = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;

  // Configuration registers
  logic [LAMBDA_W-1:0] penalty_lambda;
  logic [SWEEP_W-1:0]  max_iterations;
  logic [TOL_W-1:0]    tolerance_squared;
  logic [SIZE_W-1:0]   size_in_use;

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] idx_i, idx_j;
  logic             in_ready;

  // Take register writes at any time; the host writes only while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_lambda    <= '0;
      max_iterations    <= SWEEP_W'(100);
      tolerance_squared <= TOL_W'(1);
      size_in_use       <= SIZE_W'(16);
    end else if (write_enable) begin
      case (reg_idx_t'(register_index))
        REG_LAMBDA:   penalty_lambda    <= write_data[LAMBDA_W-1:0];
        REG_MAX_ITER: max_iterations    <= write_data[SWEEP_W-1:0];
        REG_TOL:      tolerance_squared <= write_data[TOL_W-1:0];
        REG_SIZE:     size_in_use       <= write_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready only while idle; a load transfer writes its store in the same cycle.
  assign items.ready = in_ready;

  lcdg_ctrl #(.MAX_COEFS(MAX_COEFS), .IDX_W(IDX_W)) u_ctrl (
    .clk,
    .rst,
    .in_valid   (items.valid),
    .in_command (items.command),
    .in_ready,
    .max_iter   (max_iterations),
    .size_in_use,
    .sts,
    .cmd,
    .idx_i,
    .idx_j
  );

  lcdg_datapath #(.MAX_COEFS(MAX_COEFS), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_dp (
    .clk,
    .rst,
    .cmd,
    .idx_i,
    .idx_j,
    .ld_command (items.command),
    .ld_row     (items.row_index),
    .ld_col     (items.col_index),
    .ld_value   (items.value),
    .lambda     (penalty_lambda),
    .tol        (tolerance_squared),
    .sts,
    .coefs
  );

endmodule

[dv/tb_lasso_coordinate_descent_gram.sv]
// ----------------------------------------------------------------------------
// tb_lasso_coordinate_descent_gram
// Self-checking bench for the lasso coordinate descent block: loads Gram,
// target and start values, runs fits under many register settings, and
// compares every emitted coefficient with an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_lasso_coordinate_descent_gram;
  import lcdg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOEF = 16;
  localparam int FRAC  = 16;

  // Scoreboard: holds a private copy of the stores and registers, predicts
  // the coefficients of each run and checks them in order.
  class coef_scoreboard;
    typedef struct {
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic [15:0]        sweeps;
      bit                 conv;
      bit                 bad;
      bit                 last;
    } coef_res_t;

    logic [30:0] lambda_q;
    logic [15:0] sweep_cap;
    logic [31:0] tol_sq;
    logic [4:0]  size_reg;
    int gram[NCOEF][NCOEF];
    int target[NCOEF];
    int coef[NCOEF];
    int prev[NCOEF];
    coef_res_t expected_coefs[$];
    int errors, results, runs, conv_runs, bad_runs;

    function new();
      lambda_q = 0; sweep_cap = 100; tol_sq = 1; size_reg = 16;
    endfunction

    function int pending();
      return expected_coefs.size();
    endfunction

    function int fit_size();
      if (size_reg == 0) return 1;
      if (size_reg > NCOEF) return NCOEF;
      return size_reg;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_LAMBDA:   lambda_q = d[30:0];
        REG_MAX_ITER: sweep_cap = d[15:0];
        REG_TOL:      tol_sq = d;
        REG_SIZE:     size_reg = d[4:0];
        default: ;
      endcase
    endfunction

    function longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    function logic [63:0] uadd_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    // change < eps * prev / 2^32, quotient saturated to 64 bits
    function bit below_tol(logic [63:0] chg, logic [63:0] prv, logic [31:0] eps);
      logic [127:0] p;
      logic [63:0]  q;
      p = 128'(eps) * 128'(prv);
      q = (p[127:96] != 0) ? '1 : p[95:32];
      return (chg < q) || (chg == q && p[31:0] != 0);
    endfunction

    function void fit_coefs();
      int n, sw, d;
      bit conv, bad;
      longint lam, dot, t, s, df, q;
      logic [63:0] chg, prv, ad;
      coef_res_t r;
      n = fit_size();
      lam = longint'(lambda_q) <<< FRAC;
      conv = 0; bad = 0; sw = 0;
      for (int j = 0; j < n; j++) if (gram[j][j] <= 0) bad = 1;
      prev = coef;
      while (sw < sweep_cap) begin
        for (int j = 0; j < n; j++) begin
          d = gram[j][j];
          if (d <= 0) begin
            coef[j] = 0;
            continue;
          end
          dot = 0;
          for (int i = 0; i < n; i++)
            dot = add_sat(dot, longint'(gram[i][j]) * longint'(coef[i]));
          t = add_sat(longint'(target[j]) <<< FRAC, -dot);
          // a negated minimum wraps back to the minimum: redo exactly
          if (dot == 64'sh8000_0000_0000_0000)
            t = (target[j] < 0) ? (longint'(target[j]) <<< FRAC) - dot
                                : 64'sh7FFF_FFFF_FFFF_FFFF;
          t = add_sat(t, longint'(d) * longint'(coef[j]));
          if (t > lam) s = t - lam;
          else if (t < -lam) s = t + lam;
          else s = 0;
          q = s / longint'(d);
          if (q > 64'sh7FFF_FFFF) coef[j] = 32'h7FFF_FFFF;
          else if (q < -64'sh8000_0000) coef[j] = 32'h8000_0000;
          else coef[j] = q[31:0];
        end
        sw++;
        chg = 0; prv = 0;
        for (int j = 0; j < n; j++) begin
          df = longint'(coef[j]) - longint'(prev[j]);
          ad = (df < 0) ? -df : df;
          chg = uadd_sat(chg, ad * ad);
          prv = uadd_sat(prv, 64'(longint'(prev[j]) * longint'(prev[j])));
        end
        if (below_tol(chg, prv, tol_sq)) begin
          conv = 1;
          break;
        end
        prev = coef;
      end
      runs++;
      conv_runs += conv;
      bad_runs += bad;
      for (int j = 0; j < n; j++) begin
        r.idx = j; r.val = coef[j]; r.sweeps = sw[15:0];
        r.conv = conv; r.bad = bad; r.last = (j == n - 1);
        expected_coefs.push_back(r);
      end
    endfunction

    function void note_item(cmd_t c, logic [3:0] row, logic [3:0] col,
                            logic signed [31:0] v);
      case (c)
        CMD_GRAM:   gram[row][col] = v;
        CMD_TARGET: target[row] = v;
        CMD_COEF:   coef[row] = v;
        CMD_RUN:    fit_coefs();
        default: ;
      endcase
    endfunction

    function void check_result(logic [3:0] idx, logic signed [31:0] v,
                               logic [15:0] sw, bit cv, bit bd, bit lst);
      coef_res_t e;
      results++;
      if (expected_coefs.size() == 0) begin
        $error("unexpected coefficient transfer idx=%0d value=%0d", idx, v);
        errors++;
        return;
      end
      e = expected_coefs.pop_front();
      if (idx !== e.idx) begin
        $error("coef_index: expected %0d, got %0d", e.idx, idx); errors++;
      end
      if (v !== e.val) begin
        $error("coef_value: expected %0d, got %0d", e.val, v); errors++;
      end
      if (sw !== e.sweeps) begin
        $error("sweeps_done: expected %0d, got %0d", e.sweeps, sw); errors++;
      end
      if (cv !== e.conv) begin
        $error("converged: expected %0d, got %0d", e.conv, cv); errors++;
      end
      if (bd !== e.bad) begin
        $error("bad_diagonal: expected %0d, got %0d", e.bad, bd); errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        write_enable;
  logic [1:0]  register_index;
  logic [31:0] write_data;

  lcdg_in_if  in_ch();
  lcdg_out_if out_ch();

  lasso_coordinate_descent_gram uut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .register_index(register_index),
    .write_data(write_data),
    .items(in_ch), .coefs(out_ch)
  );

  coef_scoreboard sb = new();

  // Track which store entries hold a loaded value; a run never reads others.
  bit g_set[NCOEF][NCOEF];
  bit y_set[NCOEF];
  bit b_set[NCOEF];
  int burst_left;
  int items_sent;
  int hold_left;
  int stall_mode;
  bit hold_req;

  initial clk = 0;

  always #10 clk = ~clk;

  // Monitor: every accepted input transfer updates the predictor, every
  // accepted coefficient gets checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_item(cmd_t'(in_ch.command), in_ch.row_index, in_ch.col_index,
                   in_ch.value);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.coef_index, out_ch.coef_value, out_ch.sweeps_done,
                      out_ch.converged, out_ch.bad_diagonal, out_ch.last);
  end

  // Receiver: stall pattern changes mode now and then; a long hold-off,
  // counted here, is started on request from the stimulus.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 2500;
      hold_req = 0;
    end
    if ($urandom_range(0, 149) == 0) stall_mode = $urandom_range(0, 2);
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one item and hold it until the transfer. The sender works in
  // bursts; between bursts it may drop valid for a random gap.
  task automatic send_item(cmd_t c, logic [3:0] row, logic [3:0] col,
                           logic signed [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.row_index <= row;
    in_ch.col_index <= col;
    in_ch.value     <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    case (c)
      CMD_GRAM:   g_set[row][col] = 1;
      CMD_TARGET: y_set[row] = 1;
      CMD_COEF:   b_set[row] = 1;
      default: ;
    endcase
  endtask

  // Drop valid and hold until every expected coefficient has come out,
  // then give the block time to settle back to idle. The first
  // edge lets the monitor note an item accepted at the current edge.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] d);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= d;
    sb.set_register(idx, d);
    @(posedge clk);
  endtask

  task automatic end_writes();
    write_enable <= 1'b0;
  endtask

  // Mostly well-conditioned data: strong positive diagonal, small coupling.
  // The rest is full-range noise and the odd non-positive diagonal.
  function automatic logic signed [31:0] pick_value(cmd_t c, bit on_diag);
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) return $urandom;
    if (c == CMD_GRAM && on_diag) begin
      if (k < 17) return -$urandom_range(0, 1 << 16);
      return $urandom_range(1 << 16, 8 << 16);
    end
    if (c == CMD_GRAM) return $signed($urandom_range(0, 1 << 15)) - (1 << 14);
    if (c == CMD_TARGET) return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
  endfunction

  task automatic ensure_loaded(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!g_set[i][j]) send_item(CMD_GRAM, i, j, pick_value(CMD_GRAM, i == j));
    for (int i = 0; i < n; i++) begin
      if (!y_set[i]) send_item(CMD_TARGET, i, 0, pick_value(CMD_TARGET, 0));
      if (!b_set[i]) send_item(CMD_COEF, i, 0, pick_value(CMD_COEF, 0));
    end
  endtask

  task automatic random_load(int n);
    cmd_t c;
    logic [3:0] r, cl;
    c  = cmd_t'($urandom_range(0, 2));
    r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    send_item(c, r, cl, pick_value(c, r == cl));
  endtask

  initial begin
    int n, per_sweep, cap, loads, k;
    logic [31:0] d;
    in_ch.valid = 0; in_ch.command = 0; in_ch.row_index = 0;
    in_ch.col_index = 0; in_ch.value = 0;
    write_enable = 0; register_index = 0; write_data = 0;
    out_ch.ready = 0;
    hold_req = 0; hold_left = 0; stall_mode = 0;
    burst_left = 0; items_sent = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single coefficient, sweep cap at its maximum: the exact update settles
    // on the second sweep, so the loose tolerance ends the run early.
    write_reg(REG_SIZE, 1);
    write_reg(REG_MAX_ITER, 65535);
    write_reg(REG_TOL, 32'hFFFF_FFFF);
    write_reg(REG_LAMBDA, 0);
    end_writes();
    send_item(CMD_GRAM, 0, 0, 1 << 16);
    send_item(CMD_TARGET, 0, 0, 10 << 16);
    send_item(CMD_COEF, 0, 0, 0);
    send_item(CMD_RUN, 0, 0, 0);
    drain();

    // Zero sweep cap: start values come back untouched, extremes included.
    write_reg(REG_SIZE, 2);
    write_reg(REG_MAX_ITER, 0);
    end_writes();
    send_item(CMD_GRAM, 0, 1, 32'h8000_0000);
    send_item(CMD_GRAM, 1, 0, 32'h7FFF_FFFF);
    send_item(CMD_GRAM, 1, 1, 2 << 16);
    send_item(CMD_TARGET, 1, 0, -(3 << 16));
    send_item(CMD_COEF, 0, 0, 32'h7FFF_FFFF);
    send_item(CMD_COEF, 1, 0, 32'h8000_0000);
    send_item(CMD_RUN, 4'hF, 4'hF, 32'hFFFF_FFFF);
    drain();

    // Tiny diagonal drives the quotient into saturation; a zero diagonal
    // flags every result of the run. Zero tolerance never converges.
    write_reg(REG_MAX_ITER, 1);
    write_reg(REG_TOL, 0);
    end_writes();
    send_item(CMD_GRAM, 0, 0, 1);
    send_item(CMD_TARGET, 0, 0, 32'h7FFF_FFFF);
    send_item(CMD_GRAM, 1, 1, 0);
    send_item(CMD_RUN, 0, 0, 0);
    drain();

    // Largest penalty shrinks everything to zero; negative diagonal.
    write_reg(REG_LAMBDA, 32'h7FFF_FFFF);
    write_reg(REG_MAX_ITER, 2);
    end_writes();
    send_item(CMD_GRAM, 1, 1, -5);
    send_item(CMD_RUN, 0, 0, 0);
    drain();

    // Size zero acts as one; an oversize value acts as the full sixteen,
    // here with a zero sweep cap so only diagonals and start values are read.
    write_reg(REG_SIZE, 0);
    write_reg(REG_LAMBDA, 1 << 10);
    write_reg(REG_MAX_ITER, 1);
    end_writes();
    send_item(CMD_RUN, 0, 0, 0);
    drain();
    write_reg(REG_SIZE, 31);
    write_reg(REG_TOL, 32'h0100_0000);
    write_reg(REG_MAX_ITER, 0);
    end_writes();
    for (int i = 0; i < NCOEF; i++) begin
      if (!g_set[i][i]) send_item(CMD_GRAM, i, i, pick_value(CMD_GRAM, 1));
      if (!b_set[i]) send_item(CMD_COEF, i, 0, pick_value(CMD_COEF, 0));
    end
    send_item(CMD_RUN, 0, 0, 0);
    drain();

    // Random phases: fresh registers, a handful of loads, then one or two runs.
    // Sweep caps are scaled to the cost of a sweep so that each run stays short.
    while (items_sent < 260) begin
      k = $urandom_range(0, 99);
      n = (k < 50) ? $urandom_range(1, 3) : (k < 90) ? $urandom_range(4, 8)
                                                     : $urandom_range(9, 16);
      // Keep the full-load cost of a late phase near the item budget.
      while (n > 1 && items_sent + n * (n + 2) > 300) n--;
      per_sweep = n * (3 * n + 70) + 5 * n + 3;
      cap = 6000 / per_sweep;
      if (cap < 1) cap = 1;
      write_reg(REG_SIZE, ($urandom_range(0, 9) == 0 && n == 16) ? 20 : n);
      write_reg(REG_MAX_ITER, ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, cap));
      k = $urandom_range(0, 9);
      d = (k == 0) ? 0 : (k == 1) ? 32'hFFFF_FFFF : (k < 5) ? $urandom : $urandom_range(1, 1 << 20);
      write_reg(REG_TOL, d);
      k = $urandom_range(0, 9);
      d = (k < 3) ? 0 : (k == 3) ? 32'h7FFF_FFFF : (k == 4) ? $urandom : $urandom_range(0, 1 << 16);
      write_reg(REG_LAMBDA, d);
      end_writes();
      if (sb.runs == 6 || $urandom_range(0, 11) == 0) begin
        // Long receiver hold-off while loads and runs keep coming.
        hold_req = 1;
      end
      for (int r = 0; r < $urandom_range(1, 2); r++) begin
        loads = $urandom_range(2, 10);
        repeat (loads) random_load(n);
        ensure_loaded(n);
        send_item(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end
      // Register writes need an idle block.
      drain();
    end

    drain();
    $display("Run covered %0d items, %0d fits and %0d coefficient transfers.",
             items_sent, sb.runs, sb.results);
    $display("Fits that converged: %0d; fits with a flagged diagonal: %0d.",
             sb.conv_runs, sb.bad_runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
